/* rtl/core/hslp_pkg.sv */
package hslp_pkg;

	// Shortest status line that can pass.
	localparam int DEF_MIN_LINE_LENGTH = 12;

	// Width of the digit counter, which saturates at four.
	localparam int DIGIT_CNT_W = 3;
	localparam logic [DIGIT_CNT_W-1:0] DIGITS_WANTED = 3'd3;
	localparam logic [DIGIT_CNT_W-1:0] DIGITS_TOO_MANY = 3'd4;

	localparam int CODE_W = 10;

	// ASCII codes the parser looks for.
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_PREFIX = 3'd0,
		PH_SEEK   = 3'd1,
		PH_SKIP   = 3'd2,
		PH_DIGITS = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	// One beat of the byte stream.
	typedef struct packed {
		logic [7:0] line_byte;
		logic       is_last;
	} byte_beat_t;

	// One beat of the result stream.
	typedef struct packed {
		logic              parse_ok;
		logic [CODE_W-1:0] status_code;
	} result_beat_t;

	// Expected text of the first four bytes: "HTTP".
	function automatic logic [7:0] prefix_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = 8'h48;
			2'd1: c = 8'h54;
			2'd2: c = 8'h54;
			2'd3: c = 8'h50;
			default: c = 8'h50;
		endcase
		return c;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
	endfunction

endpackage

/* rtl/core/hslp_in_stage.sv */
module hslp_in_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  hslp_pkg::byte_beat_t  byte_data,
	input  logic                  advance,
	output logic                  valid_s1,
	output hslp_pkg::byte_beat_t  data_s1
);

	logic load;

	// The register takes a new beat when it is empty or its beat moves on.
	assign load = !valid_s1 || advance;
	assign byte_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= byte_valid;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (load && byte_valid) begin
			data_s1 <= byte_data;
		end
	end

endmodule

/* rtl/core/hslp_core.sv */
module hslp_core #(
	parameter int MIN_LINE_LENGTH = hslp_pkg::DEF_MIN_LINE_LENGTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_s1,
	input  hslp_pkg::byte_beat_t   data_s1,
	output logic                   advance,
	output logic                   result_valid,
	input  logic                   result_stall,
	output hslp_pkg::result_beat_t result_data
);

	localparam int CntW = $clog2(MIN_LINE_LENGTH + 1);
	localparam logic [CntW-1:0] MinLen = CntW'(MIN_LINE_LENGTH);
	localparam logic [CntW-1:0] LastPrefixPos = CntW'(3);

	localparam int CW = hslp_pkg::CODE_W;
	localparam int DW = hslp_pkg::DIGIT_CNT_W;

	hslp_pkg::phase_t  phase_q, phase_nxt;
	logic [CntW-1:0]   byte_count_q, byte_count_nxt;
	logic              prefix_bad_q, prefix_bad_nxt;
	logic [CW-1:0]     code_acc_q, code_acc_nxt;
	logic [DW-1:0]     digit_count_q, digit_count_nxt;

	logic [7:0]        b;
	logic [CW-1:0]     digit_val;
	logic              take;
	logic              line_ok;
	logic              result_taken;
	hslp_pkg::result_beat_t result_nxt;

	assign b = data_s1.line_byte;
	assign digit_val = CW'(b - hslp_pkg::CHAR_ZERO);
	assign result_taken = result_valid && !result_stall;

	// A last byte moves on only when the result register is free or is emptied now.
	assign advance = valid_s1 && (!data_s1.is_last || !result_valid || !result_stall);
	assign take = advance;

	// Next state for one byte.
	always_comb begin
		phase_nxt = phase_q;
		prefix_bad_nxt = prefix_bad_q;
		code_acc_nxt = code_acc_q;
		digit_count_nxt = digit_count_q;
		byte_count_nxt = (byte_count_q < MinLen) ? byte_count_q + 1'b1 : byte_count_q;

		unique case (phase_q)
			hslp_pkg::PH_PREFIX: begin
				if (b != hslp_pkg::prefix_char(byte_count_q[1:0])) begin
					prefix_bad_nxt = 1'b1;
				end
				if (byte_count_q >= LastPrefixPos) begin
					phase_nxt = hslp_pkg::PH_SEEK;
				end
			end
			hslp_pkg::PH_SEEK: begin
				if (b == hslp_pkg::CHAR_SPACE) begin
					phase_nxt = hslp_pkg::PH_SKIP;
				end
			end
			hslp_pkg::PH_SKIP, hslp_pkg::PH_DIGITS: begin
				if (hslp_pkg::is_digit(b)) begin
					phase_nxt = hslp_pkg::PH_DIGITS;
					if (digit_count_q < hslp_pkg::DIGITS_WANTED) begin
						code_acc_nxt = (code_acc_q << 3) + (code_acc_q << 1) + digit_val;
						digit_count_nxt = digit_count_q + 1'b1;
					end else begin
						digit_count_nxt = hslp_pkg::DIGITS_TOO_MANY;
					end
				end else if (!(phase_q == hslp_pkg::PH_SKIP && b == hslp_pkg::CHAR_SPACE)) begin
					phase_nxt = hslp_pkg::PH_DONE;
				end
			end
			default: begin
				// Stopped, and unused codes: only the byte count moves.
			end
		endcase
	end

	// Verdict from the state after this byte.
	always_comb begin
		line_ok = !prefix_bad_nxt && (byte_count_nxt >= MinLen) &&
			(digit_count_nxt == hslp_pkg::DIGITS_WANTED);
		result_nxt.parse_ok = line_ok;
		result_nxt.status_code = line_ok ? code_acc_nxt : '0;
	end

	// Parser state; a last byte returns it to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hslp_pkg::PH_PREFIX;
			byte_count_q <= '0;
			prefix_bad_q <= 1'b0;
			code_acc_q <= '0;
			digit_count_q <= '0;
		end else if (take) begin
			if (data_s1.is_last) begin
				phase_q <= hslp_pkg::PH_PREFIX;
				byte_count_q <= '0;
				prefix_bad_q <= 1'b0;
				code_acc_q <= '0;
				digit_count_q <= '0;
			end else begin
				phase_q <= phase_nxt;
				byte_count_q <= byte_count_nxt;
				prefix_bad_q <= prefix_bad_nxt;
				code_acc_q <= code_acc_nxt;
				digit_count_q <= digit_count_nxt;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (take && data_s1.is_last) begin
			result_valid <= 1'b1;
		end else if (result_taken) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && data_s1.is_last) begin
			result_data <= result_nxt;
		end
	end

	// A failed line never reports a code.
	a_fail_zero_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_data.parse_ok || result_data.status_code == '0))
		else $error("failed line carries a nonzero status code");

	// Digit count saturates at four.
	a_digit_sat: assert property (@(posedge clk) disable iff (!arst_n)
		digit_count_q <= hslp_pkg::DIGITS_TOO_MANY)
		else $error("digit count beyond saturation");

	// In the digit phase at least one digit has been seen.
	a_digits_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == hslp_pkg::PH_DIGITS) |-> (digit_count_q != '0))
		else $error("digit phase with no digit");

	// The end of a line leaves the parser in its reset state.
	a_line_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(take && data_s1.is_last) |=>
			(phase_q == hslp_pkg::PH_PREFIX && byte_count_q == '0 &&
			 digit_count_q == '0 && !prefix_bad_q))
		else $error("state not cleared after last byte");

	// A pending result is never overwritten before it is taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |-> !(take && data_s1.is_last))
		else $error("result register overwritten while stalled");

endmodule

/* rtl/core/http_status_line_parser_top.sv */
// Path: the last byte passes the input register; its result is then held in
// the result register until taken. Throughput: one byte per cycle while
// byte_stall is low; the parser state is updated by a single registered pass
// per byte, and the result register takes one result per cycle while
// result_stall is low. Reset: arst_n is asynchronous and active low; it empties
// both registers and returns the parser to the prefix check of a new line.
module http_status_line_parser_top #(
	parameter int MIN_LINE_LENGTH = hslp_pkg::DEF_MIN_LINE_LENGTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  hslp_pkg::byte_beat_t   byte_data,
	output logic                   result_valid,
	input  logic                   result_stall,
	output hslp_pkg::result_beat_t result_data
);

	logic                 valid_s1;
	hslp_pkg::byte_beat_t data_s1;
	logic                 advance;

	// Input register.
	hslp_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data (byte_data),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.data_s1   (data_s1)
	);

	// Parser state and result register.
	hslp_core #(
		.MIN_LINE_LENGTH(MIN_LINE_LENGTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.data_s1     (data_s1),
		.advance     (advance),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data (result_data)
	);

endmodule

/* dv/http_status_line_parser_top_tb.sv */
`timescale 1ns / 100ps

module http_status_line_parser_top_tb;

	localparam int MIN_LEN = hslp_pkg::DEF_MIN_LINE_LENGTH;
	localparam int LINE_BYTES = 1500;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam logic [31:0] HTTP_WORD = "HTTP";

	typedef logic [7:0] byte_q_t[$];

	// Predicts the result of each status line and checks the result beats in order.
	class status_line_scoreboard;
		hslp_pkg::phase_t       phase;
		logic [3:0]             byte_cnt;
		logic                   prefix_bad;
		logic [9:0]             code_acc;
		logic [2:0]             digit_cnt;
		hslp_pkg::result_beat_t expected_q[$];
		int                     n_errors;
		int                     n_checked;
		int                     n_good;

		function new();
			clear_line();
			n_errors = 0;
			n_checked = 0;
			n_good = 0;
		endfunction

		function void clear_line();
			phase = hslp_pkg::PH_PREFIX;
			byte_cnt = '0;
			prefix_bad = 1'b0;
			code_acc = '0;
			digit_cnt = '0;
		endfunction

		function void add_digit(logic [7:0] b);
			if (digit_cnt < hslp_pkg::DIGITS_WANTED) begin
				code_acc = 10'(code_acc * 10 + (b - hslp_pkg::CHAR_ZERO));
				digit_cnt = digit_cnt + 1'b1;
			end else begin
				digit_cnt = hslp_pkg::DIGITS_TOO_MANY;
			end
		endfunction

		// Advances the parser by one accepted byte; the final byte queues a result.
		function void note_byte(hslp_pkg::byte_beat_t beat);
			logic [3:0]             pos;
			logic                   digit;
			hslp_pkg::result_beat_t want;
			pos = byte_cnt;
			digit = (beat.line_byte >= hslp_pkg::CHAR_ZERO) &&
				(beat.line_byte <= hslp_pkg::CHAR_NINE);
			if (byte_cnt < MIN_LEN)
				byte_cnt = byte_cnt + 1'b1;
			case (phase)
				hslp_pkg::PH_PREFIX: begin
					if (beat.line_byte != HTTP_WORD[31 - 8 * pos[1:0] -: 8])
						prefix_bad = 1'b1;
					if (pos >= 3)
						phase = hslp_pkg::PH_SEEK;
				end
				hslp_pkg::PH_SEEK: begin
					if (beat.line_byte == hslp_pkg::CHAR_SPACE)
						phase = hslp_pkg::PH_SKIP;
				end
				hslp_pkg::PH_SKIP: begin
					if (beat.line_byte == hslp_pkg::CHAR_SPACE) begin
						phase = hslp_pkg::PH_SKIP;
					end else if (digit) begin
						add_digit(beat.line_byte);
						phase = hslp_pkg::PH_DIGITS;
					end else begin
						phase = hslp_pkg::PH_DONE;
					end
				end
				hslp_pkg::PH_DIGITS: begin
					if (digit)
						add_digit(beat.line_byte);
					else
						phase = hslp_pkg::PH_DONE;
				end
				default: begin
				end
			endcase
			if (beat.is_last) begin
				want.parse_ok = !prefix_bad && (byte_cnt >= MIN_LEN) &&
					(digit_cnt == hslp_pkg::DIGITS_WANTED);
				want.status_code = want.parse_ok ? code_acc : '0;
				expected_q.push_back(want);
				clear_line();
			end
		endfunction

		// Compares one result beat with the oldest expected result.
		function void check_result(hslp_pkg::result_beat_t got);
			hslp_pkg::result_beat_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result beat: parse_ok=%0d status_code=%0d",
					got.parse_ok, got.status_code);
				n_errors++;
				return;
			end
			want = expected_q.pop_front();
			n_checked++;
			if (want.parse_ok)
				n_good++;
			if (got.parse_ok !== want.parse_ok) begin
				$error("parse_ok: expected %0d, got %0d", want.parse_ok, got.parse_ok);
				n_errors++;
			end
			if (got.status_code !== want.status_code) begin
				$error("status_code: expected %0d, got %0d", want.status_code,
					got.status_code);
				n_errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   byte_valid;
	logic                   byte_stall;
	hslp_pkg::byte_beat_t   byte_data;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	hslp_pkg::result_beat_t result_data;

	status_line_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int bytes_sent = 0;
	int lines_sent = 0;
	logic hold_off = 1'b0;

	http_status_line_parser_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Result side: random stalls, plus the long hold-off when requested.
	always @(posedge clk) begin
		if (result_valid && !result_stall)
			sb.check_result(result_data);
		result_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
	end

	// Holds the result side off for a long stretch so the parser backs up.
	initial begin
		wait (bytes_sent >= 1100);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Ends the run when no beat moves on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout after %0d quiet cycles", QUIET_LIMIT);
		$display("http_status_line_parser_top_tb failed");
		$finish;
	end

	function automatic byte_q_t text_bytes(string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	// Builds one line: mostly well-formed status lines, some cut short, some noise.
	function automatic byte_q_t random_line();
		byte_q_t    q;
		int         kind;
		int         n;
		logic [7:0] b;
		kind = $urandom_range(99);
		if (kind < 85) begin
			q = text_bytes("HTTP");
			if ($urandom_range(19) == 0)
				q[$urandom_range(3)] = 8'($urandom_range(255));
			n = $urandom_range(4);
			repeat (n) begin
				do b = 8'($urandom_range(255)); while (b == hslp_pkg::CHAR_SPACE);
				q.push_back(b);
			end
			n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
			repeat (n) q.push_back(hslp_pkg::CHAR_SPACE);
			n = ($urandom_range(3) == 0) ? $urandom_range(5) : 3;
			repeat (n) q.push_back(8'(hslp_pkg::CHAR_ZERO + $urandom_range(9)));
			n = $urandom_range(6);
			repeat (n) q.push_back(8'($urandom_range(255)));
			if (kind >= 70) begin
				n = $urandom_range(1, q.size());
				while (q.size() > n)
					void'(q.pop_back());
			end
		end else begin
			if ($urandom_range(2) == 0)
				q = text_bytes("HTTP");
			n = $urandom_range(1, 20);
			repeat (n) q.push_back(8'($urandom_range(255)));
		end
		return q;
	endfunction

	// Offers one byte beat and waits until the parser takes it.
	task automatic send_byte(input hslp_pkg::byte_beat_t beat);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= beat;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		sb.note_byte(beat);
		bytes_sent++;
	endtask

	task automatic send_line(input byte_q_t q);
		hslp_pkg::byte_beat_t beat;
		for (int i = 0; i < q.size(); i++) begin
			beat.line_byte = q[i];
			beat.is_last = (i == q.size() - 1);
			send_byte(beat);
		end
		lines_sent++;
	endtask

	initial begin
		byte_q_t q;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines: minimum length, extra spaces, too many digits, no space,
		// bad prefix, short lines, a non-digit after the spaces, extreme bytes.
		send_line(text_bytes("HTTP/1.1 200"));
		send_line(text_bytes("HTTP   000 X"));
		send_line(text_bytes("HTTP 9999 ab"));
		send_line(text_bytes("HTTPx1234567"));
		send_line(text_bytes("HTTQ/1 404 x"));
		send_line(text_bytes("HTTP 200"));
		send_line(text_bytes("H"));
		send_line(text_bytes("HTT"));
		send_line(text_bytes("HTTP x12 abc"));
		q = text_bytes("HTTP 301");
		q.push_back(8'h00);
		q.push_back(8'hFF);
		q.push_back(8'h00);
		q.push_back(8'hFF);
		send_line(q);

		// Random lines under three idle patterns.
		send_idle_pct = 20;
		recv_stall_pct = 45;
		while (bytes_sent < LINE_BYTES / 3)
			send_line(random_line());
		send_idle_pct = 45;
		recv_stall_pct = 20;
		while (bytes_sent < 2 * LINE_BYTES / 3)
			send_line(random_line());
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (bytes_sent < LINE_BYTES)
			send_line(random_line());
		byte_valid <= 1'b0;

		// Drain outstanding results, then allow for the output latency.
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d status lines (%0d bytes) under three idle patterns and one long",
			lines_sent, bytes_sent);
		$display("result hold-off; checked %0d results, %0d with a valid status code.",
			sb.n_checked, sb.n_good);
		if (sb.n_errors == 0 && sb.expected_q.size() == 0)
			$display("http_status_line_parser_top_tb passed");
		else
			$display("http_status_line_parser_top_tb failed");
		$finish;
	end

endmodule
